[hw/rtl/ig3_pkg.sv]
// Shared constants and types for the 3x3 image gradient block.
package ig3_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int PIXEL_IN_W = 8;
  localparam int DIM_W      = 12;
  localparam int COL_OUT_W  = 11;
  localparam int GRAD_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_MODE = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [DIM_W-1:0] FRAME_MIN        = 12'd3;

  localparam logic MODE_CENTRAL = 1'b0;
  localparam logic MODE_SOBEL   = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] h_last;
    logic             mode;
  } frame_cfg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [DIM_W-1:0]         rc;
    logic [DIM_W-1:0]         cc;
    logic                     top;
    logic                     bot;
    logic                     left;
    logic                     right;
  } centre_t;

endpackage

[hw/rtl/image_gradient_3x3.sv]
// Top level of the streaming 3x3 image gradient block.
// Usage:
//   Pixels enter in raster order on in_pixel, one per in_valid/in_ready transaction.
//   Each pixel at row r >= 2, column c >= 2 yields the x/y derivative of the centre
//   (r-1, c-1) plus every border copy of it, rows then columns in increasing order,
//   one out_ transaction each; out_last_of_run marks the final one of a pixel and
//   out_end_of_frame the bottom-right corner. Other pixels yield nothing.
//   Frame size and mode are written on cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   A result is registered in the stage 1, sequencer and output registers in turn after its pixel is accepted.
//   One pixel per cycle while each pixel yields at most one result and out_ready is high;
//   a pixel that yields several results holds the input until the single output sequencer
//   has taken them all. The line store is read at acceptance and written one stage later.
// Reset:
//   Counters return to the first pixel of a frame and registers to 640x480,
//   central differences. The line store is not cleared.
// Stall:
//   With out_ready low the output register holds its result; at most one more centre is
//   taken, and in_ready drops once a pixel that yields a result waits in stage 1.
module image_gradient_3x3 #(
  parameter int MAX_WIDTH  = ig3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ig3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ig3_pkg::PIXEL_IN_W-1:0]       in_pixel,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ig3_pkg::DIM_W-1:0]            out_row,
  output logic [ig3_pkg::COL_OUT_W-1:0]        out_col,
  output logic signed [ig3_pkg::GRAD_W-1:0]    out_grad_x,
  output logic signed [ig3_pkg::GRAD_W-1:0]    out_grad_y,
  output logic                                 out_last_of_run,
  output logic                                 out_end_of_frame,
  input  logic                                 cfg_we,
  input  logic [ig3_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ig3_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [ig3_pkg::DIM_W-1:0] frame_width_r;
  logic [ig3_pkg::DIM_W-1:0] frame_height_r;
  logic                      mode_r;
  logic [ig3_pkg::DIM_W-1:0] row_r, row_nxt;
  logic [ig3_pkg::DIM_W-1:0] col_r, col_nxt;
  logic [ig3_pkg::DIM_W-1:0] w_eff, h_eff;

  ig3_pkg::frame_cfg_t       cfg;
  ig3_pkg::centre_t          itm;
  logic                      itm_valid;
  logic                      emit_ready;
  logic                      s1_ready;
  logic                      in_fire;
  logic [PIXEL_BITS-1:0]     px;
  logic [2*PIXEL_BITS-1:0]   rd_data;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [2*PIXEL_BITS-1:0]   wr_data;

  assign in_ready = s1_ready;
  assign in_fire  = in_valid && s1_ready;
  assign px       = PIXEL_BITS'(in_pixel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ig3_pkg::FRAME_WIDTH_RST;
      frame_height_r <= ig3_pkg::FRAME_HEIGHT_RST;
      mode_r         <= ig3_pkg::MODE_CENTRAL;
    end else if (cfg_we) begin
      case (cfg_index)
        ig3_pkg::REG_FRAME_WIDTH:   frame_width_r  <= cfg_data;
        ig3_pkg::REG_FRAME_HEIGHT:  frame_height_r <= cfg_data;
        ig3_pkg::REG_GRADIENT_MODE: mode_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = frame_width_r;
    if (frame_width_r < ig3_pkg::FRAME_MIN) begin
      w_eff = ig3_pkg::FRAME_MIN;
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = ig3_pkg::DIM_W'(MAX_WIDTH);
    end
    h_eff = (frame_height_r < ig3_pkg::FRAME_MIN) ? ig3_pkg::FRAME_MIN : frame_height_r;
    cfg.w_last = w_eff - 12'd1;
    cfg.h_last = h_eff - 12'd1;
    cfg.mode   = mode_r;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fire) begin
      if (col_r >= cfg.w_last) begin
        col_nxt = '0;
        row_nxt = (row_r >= cfg.h_last) ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  ig3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIXEL_BITS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (AW'(col_r)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ig3_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_px      (px),
    .in_row     (row_r),
    .in_col     (col_r),
    .rd_data    (rd_data),
    .cfg        (cfg),
    .emit_ready (emit_ready),
    .s1_ready   (s1_ready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .itm_valid  (itm_valid),
    .itm        (itm)
  );

  ig3_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .itm_valid        (itm_valid),
    .itm              (itm),
    .cfg              (cfg),
    .emit_ready       (emit_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

[hw/rtl/ig3_line_mem.sv]
// Line store: upper and middle row pixels per column, registered read.
module ig3_line_mem #(
  parameter int DEPTH = ig3_pkg::MAX_WIDTH_DEF,
  parameter int DW    = 2 * ig3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DW-1:0]                         rd_data,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DW-1:0]                         wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/ig3_window.sv]
// Read stage: 3x3 window, line store write-back and derivative computation.
module ig3_window #(
  parameter int MAX_WIDTH  = ig3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = ig3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_fire,
  input  logic [PIXEL_BITS-1:0]                  in_px,
  input  logic [ig3_pkg::DIM_W-1:0]              in_row,
  input  logic [ig3_pkg::DIM_W-1:0]              in_col,
  input  logic [2*PIXEL_BITS-1:0]                rd_data,
  input  ig3_pkg::frame_cfg_t                    cfg,
  input  logic                                   emit_ready,
  output logic                                   s1_ready,
  output logic                                   wr_en,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
  output logic [2*PIXEL_BITS-1:0]                wr_data,
  output logic                                   itm_valid,
  output ig3_pkg::centre_t                       itm
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PB = PIXEL_BITS;
  localparam int GW = PIXEL_BITS + 4;

  logic                       s1_valid_r;
  logic [PB-1:0]              s1_px_r;
  logic [ig3_pkg::DIM_W-1:0]  s1_row_r;
  logic [ig3_pkg::DIM_W-1:0]  s1_col_r;
  logic [PB-1:0]              win_r [6];

  logic [PB-1:0]              up_px;
  logic [PB-1:0]              mid_px;
  logic                       has_res;
  logic                       s1_go;
  logic signed [GW-1:0]       nw, wm, sw, nn, ss, ne, em, se;
  logic signed [GW-1:0]       dx, dy, gx_full, gy_full;
  logic [ig3_pkg::DIM_W-1:0]  rc, cc;

  assign up_px   = rd_data[2*PB-1:PB];
  assign mid_px  = rd_data[PB-1:0];
  assign has_res = (s1_row_r >= 12'd2) && (s1_col_r >= 12'd2);
  assign s1_go   = s1_valid_r && (!has_res || emit_ready);
  assign s1_ready = !s1_valid_r || s1_go;

  assign wr_en   = s1_go;
  assign wr_addr = AW'(s1_col_r);
  assign wr_data = {mid_px, s1_px_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r  <= in_px;
      s1_row_r <= in_row;
      s1_col_r <= in_col;
    end
  end

  // columns c-2 in entries 0..2, c-1 in 3..5 (top, middle, bottom)
  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_px;
      win_r[4] <= mid_px;
      win_r[5] <= s1_px_r;
    end
  end

  always_comb begin
    nw = $signed({4'b0, win_r[0]});
    wm = $signed({4'b0, win_r[1]});
    sw = $signed({4'b0, win_r[2]});
    nn = $signed({4'b0, win_r[3]});
    ss = $signed({4'b0, win_r[5]});
    ne = $signed({4'b0, up_px});
    em = $signed({4'b0, mid_px});
    se = $signed({4'b0, s1_px_r});
    dx = em - wm;
    dy = ss - nn;
    if (cfg.mode == ig3_pkg::MODE_SOBEL) begin
      gx_full = (dx <<< 1) + ne + se - nw - sw;
      gy_full = (dy <<< 1) + se + sw - ne - nw;
    end else begin
      gx_full = dx <<< 2;
      gy_full = dy <<< 2;
    end
  end

  assign rc = s1_row_r - 12'd1;
  assign cc = s1_col_r - 12'd1;

  assign itm_valid = s1_go && has_res;

  always_comb begin
    itm.gx    = ig3_pkg::GRAD_W'(gx_full);
    itm.gy    = ig3_pkg::GRAD_W'(gy_full);
    itm.rc    = rc;
    itm.cc    = cc;
    itm.top   = (rc == 12'd1);
    itm.bot   = (rc == cfg.h_last - 12'd1);
    itm.left  = (cc == 12'd1);
    itm.right = (cc == cfg.w_last - 12'd1);
  end

endmodule

[hw/rtl/ig3_emit.sv]
// Result sequencer: expands one centre derivative into its border copies.
module ig3_emit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 itm_valid,
  input  ig3_pkg::centre_t                     itm,
  input  ig3_pkg::frame_cfg_t                  cfg,
  output logic                                 emit_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ig3_pkg::DIM_W-1:0]            out_row,
  output logic [ig3_pkg::COL_OUT_W-1:0]        out_col,
  output logic signed [ig3_pkg::GRAD_W-1:0]    out_grad_x,
  output logic signed [ig3_pkg::GRAD_W-1:0]    out_grad_y,
  output logic                                 out_last_of_run,
  output logic                                 out_end_of_frame
);

  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_CENTRE = 2'd1;
  localparam logic [1:0] SEL_LAST   = 2'd2;

  logic                               s2_valid_r;
  ig3_pkg::centre_t                   s2_r;
  logic [1:0]                         ri_r, ri_nxt;
  logic [1:0]                         ci_r, ci_nxt;

  logic                               out_valid_r;
  logic [ig3_pkg::DIM_W-1:0]          out_row_r;
  logic [ig3_pkg::COL_OUT_W-1:0]      out_col_r;
  logic signed [ig3_pkg::GRAD_W-1:0]  grad_x_r;
  logic signed [ig3_pkg::GRAD_W-1:0]  grad_y_r;
  logic                               last_r;
  logic                               eof_r;

  logic                               fire;
  logic                               col_more, row_more, done;
  logic [ig3_pkg::DIM_W-1:0]          row_val, col_val;

  assign fire       = s2_valid_r && (!out_valid_r || out_ready);
  assign col_more   = (ci_r == SEL_FIRST) || ((ci_r == SEL_CENTRE) && s2_r.right);
  assign row_more   = (ri_r == SEL_FIRST) || ((ri_r == SEL_CENTRE) && s2_r.bot);
  assign done       = !col_more && !row_more;
  assign emit_ready = !s2_valid_r || (fire && done);

  always_comb begin
    case (ri_r)
      SEL_FIRST: row_val = '0;
      SEL_LAST:  row_val = cfg.h_last;
      default:   row_val = s2_r.rc;
    endcase
    case (ci_r)
      SEL_FIRST: col_val = '0;
      SEL_LAST:  col_val = cfg.w_last;
      default:   col_val = s2_r.cc;
    endcase
  end

  always_comb begin
    ri_nxt = ri_r;
    ci_nxt = ci_r;
    if (itm_valid) begin
      ri_nxt = itm.top ? SEL_FIRST : SEL_CENTRE;
      ci_nxt = itm.left ? SEL_FIRST : SEL_CENTRE;
    end else if (fire) begin
      if (col_more) begin
        ci_nxt = ci_r + 2'd1;
      end else if (row_more) begin
        ri_nxt = ri_r + 2'd1;
        ci_nxt = s2_r.left ? SEL_FIRST : SEL_CENTRE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (itm_valid) begin
      s2_valid_r <= 1'b1;
    end else if (fire && done) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ri_r <= ri_nxt;
    ci_r <= ci_nxt;
    if (itm_valid) begin
      s2_r <= itm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row_r <= row_val;
      out_col_r <= col_val[ig3_pkg::COL_OUT_W-1:0];
      grad_x_r  <= s2_r.gx;
      grad_y_r  <= s2_r.gy;
      last_r    <= done;
      eof_r     <= (row_val == cfg.h_last) && (col_val == cfg.w_last);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_grad_x       = grad_x_r;
  assign out_grad_y       = grad_y_r;
  assign out_last_of_run  = last_r;
  assign out_end_of_frame = eof_r;

endmodule

[test/tb_top.sv]
// Testbench for image_gradient_3x3: directed and random pixel frames checked against a scoreboard predictor.
`timescale 1ns / 1ps

module tb_top;
  import ig3_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_W        = 6;
  localparam int HOLD_H        = 4;

  // directed 3x3 frames, first pixel in the top byte
  localparam logic [71:0] CENTRAL_NEG_X = {8'd255, 8'd17, 8'd0, 8'd255, 8'd128, 8'd0,
                                           8'd255, 8'd200, 8'd0};
  localparam logic [71:0] SOBEL_POS_Y   = {8'd0, 8'd0, 8'd0, 8'd90, 8'd60, 8'd30,
                                           8'd255, 8'd255, 8'd255};
  localparam logic [71:0] CENTRAL_POS_X = {8'd0, 8'd255, 8'd0, 8'd0, 8'd77, 8'd255,
                                           8'd255, 8'd0, 8'd255};

  typedef struct packed {
    logic [DIM_W-1:0]         row;
    logic [COL_OUT_W-1:0]     col;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
    logic                     eof;
  } grad_result_t;

  class grad_scoreboard;
    logic [PIXEL_IN_W-1:0] upper_line_q [MAX_WIDTH_DEF];
    logic [PIXEL_IN_W-1:0] middle_line_q [MAX_WIDTH_DEF];
    logic [PIXEL_IN_W-1:0] window_q [6];
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic                  mode_reg;
    int unsigned           row_pos;
    int unsigned           col_pos;
    grad_result_t          expected_q [$];
    int                    errors;
    int                    checked;
    int                    pixels;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      mode_reg   = MODE_CENTRAL;
      row_pos    = 0;
      col_pos    = 0;
      errors     = 0;
      checked    = 0;
      pixels     = 0;
      foreach (upper_line_q[i]) begin
        upper_line_q[i]  = '0;
        middle_line_q[i] = '0;
      end
      foreach (window_q[i]) window_q[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:   width_reg = data;
        REG_FRAME_HEIGHT:  height_reg = data;
        REG_GRADIENT_MODE: mode_reg = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned used_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned used_height();
      if (height_reg < 3) return 3;
      return height_reg;
    endfunction

    function void note_pixel(logic [PIXEL_IN_W-1:0] px);
      int unsigned w, h, r, c, rc, cc, nr, nc;
      int unsigned rows [3];
      int unsigned cols [3];
      int nw, wm, sw, nn, ss, ne, em, se, gx, gy;
      logic [PIXEL_IN_W-1:0] up, mid;
      grad_result_t res;
      w = used_width();
      h = used_height();
      r = row_pos;
      c = col_pos;
      up  = upper_line_q[c];
      mid = middle_line_q[c];
      pixels++;
      if (r >= 2 && c >= 2) begin
        nw = window_q[0];
        wm = window_q[1];
        sw = window_q[2];
        nn = window_q[3];
        ss = window_q[5];
        ne = up;
        em = mid;
        se = px;
        if (mode_reg == MODE_SOBEL) begin
          gx = 2 * (em - wm) + (ne + se - nw - sw);
          gy = 2 * (ss - nn) + (se + sw - ne - nw);
        end else begin
          gx = 4 * (em - wm);
          gy = 4 * (ss - nn);
        end
        rc = r - 1;
        cc = c - 1;
        nr = 0;
        nc = 0;
        if (rc == 1) begin
          rows[nr] = 0;
          nr++;
        end
        rows[nr] = rc;
        nr++;
        if (rc == h - 2) begin
          rows[nr] = h - 1;
          nr++;
        end
        if (cc == 1) begin
          cols[nc] = 0;
          nc++;
        end
        cols[nc] = cc;
        nc++;
        if (cc == w - 2) begin
          cols[nc] = w - 1;
          nc++;
        end
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            res.row  = DIM_W'(rows[i]);
            res.col  = COL_OUT_W'(cols[j]);
            res.gx   = GRAD_W'(gx);
            res.gy   = GRAD_W'(gy);
            res.last = (i == nr - 1) && (j == nc - 1);
            res.eof  = (rows[i] == h - 1) && (cols[j] == w - 1);
            expected_q.push_back(res);
          end
        end
      end
      upper_line_q[c]  = mid;
      middle_line_q[c] = px;
      window_q[0] = window_q[3];
      window_q[1] = window_q[4];
      window_q[2] = window_q[5];
      window_q[3] = up;
      window_q[4] = mid;
      window_q[5] = px;
      if (c >= w - 1) begin
        col_pos = 0;
        row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check(grad_result_t got);
      grad_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: row %0d col %0d gx %0d gy %0d last %0b eof %0b",
                   got.row, got.col, got.gx, got.gy, got.last, got.eof);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.row !== exp_r.row || got.col !== exp_r.col || got.gx !== exp_r.gx ||
          got.gy !== exp_r.gy || got.last !== exp_r.last || got.eof !== exp_r.eof) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d: expected row %0d col %0d gx %0d gy %0d last %0b eof %0b",
                   checked, exp_r.row, exp_r.col, exp_r.gx, exp_r.gy, exp_r.last, exp_r.eof);
          $display("result %0d: actual   row %0d col %0d gx %0d gy %0d last %0b eof %0b",
                   checked, got.row, got.col, got.gx, got.gy, got.last, got.eof);
        end
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [PIXEL_IN_W-1:0]       in_pixel = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [DIM_W-1:0]            out_row;
  logic [COL_OUT_W-1:0]        out_col;
  logic signed [GRAD_W-1:0]    out_grad_x;
  logic signed [GRAD_W-1:0]    out_grad_y;
  logic                        out_last_of_run;
  logic                        out_end_of_frame;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  grad_scoreboard sb;
  bit calm = 1'b0;
  bit long_hold = 1'b0;
  int frames = 0;

  always #5 clk = ~clk;

  image_gradient_3x3 i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_grad_x       (out_grad_x),
    .out_grad_y       (out_grad_y),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  task automatic send_pixel(input logic [PIXEL_IN_W-1:0] px);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(px);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic mode);
    drain_results();
    put_reg(REG_FRAME_WIDTH, w);
    put_reg(REG_FRAME_HEIGHT, h);
    put_reg(REG_GRADIENT_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    frames++;
  endtask

  task automatic send_pattern(input logic [71:0] pat);
    for (int i = 0; i < 9; i++) send_pixel(pat[71 - 8 * i -: 8]);
  endtask

  task automatic send_random_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                   input logic mode, input bit binary);
    int unsigned n;
    program_frame(w, h, mode);
    n = sb.used_width() * sb.used_height();
    for (int unsigned k = 0; k < n; k++)
      send_pixel(binary ? {PIXEL_IN_W{1'($urandom)}} : PIXEL_IN_W'($urandom));
  endtask

  task automatic run_small_frames(input int target);
    int sent;
    logic [DIM_W-1:0] w, h;
    sent = 0;
    while (sent < target) begin
      w = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2)) :
                                        DIM_W'($urandom_range(3, 8));
      h = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(0, 2)) :
                                        DIM_W'($urandom_range(3, 6));
      send_random_frame(w, h, 1'($urandom), $urandom_range(0, 3) == 0);
      sent += sb.used_width() * sb.used_height();
    end
  endtask

  // receiver: random back-pressure plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check(grad_result_t'{out_row, out_col, out_grad_x, out_grad_y,
                              out_last_of_run, out_end_of_frame});
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: gradient extremes in both modes, clamped frame size
    program_frame(DIM_W'(3), DIM_W'(3), MODE_CENTRAL);
    send_pattern(CENTRAL_NEG_X);
    program_frame(DIM_W'(3), DIM_W'(3), MODE_SOBEL);
    send_pattern(SOBEL_POS_Y);
    program_frame(DIM_W'(1), DIM_W'(0), MODE_CENTRAL);
    send_pattern(CENTRAL_POS_X);

    // output held off while a whole frame keeps arriving, so the input stalls
    program_frame(DIM_W'(HOLD_W), DIM_W'(HOLD_H), MODE_SOBEL);
    long_hold = 1'b1;
    for (int k = 0; k < HOLD_W * HOLD_H; k++) send_pixel(PIXEL_IN_W'($urandom));

    // random small frames
    run_small_frames(35);

    // tail without idling
    drain_results();
    calm = 1'b1;
    run_small_frames(15);

    drain_results();
    $display("Covered %0d pixels in %0d frames, both modes, sizes 3x3 to 8x6 incl. clamped",
             sb.pixels, frames);
    $display("%0d results compared across a long output stall, %0d errors, %0d still pending",
             sb.checked, sb.errors, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ig3_pkg.sv
hw/rtl/ig3_line_mem.sv
hw/rtl/ig3_window.sv
hw/rtl/ig3_emit.sv
hw/rtl/image_gradient_3x3.sv
test/tb_top.sv
